// ===== hdl/tdu_pkg.sv =====
// Shared types and constants for the TDC data word unpacker.
// Holds word tags, result kinds and the result/decode structs.
// No dependencies; compiled first.
package tdu_pkg;

    // Word tags in bits 31..28
    typedef enum logic [3:0] {
        TAG_TRIGGER  = 4'h2,
        TAG_LEADING  = 4'h4,
        TAG_TRAILING = 4'h5,
        TAG_TRIG_FLG = 4'hA,
        TAG_GEO      = 4'hC,
        TAG_HEADER   = 4'hD,
        TAG_SEPARATE = 4'hE
    } tag_t;

    // Result kinds
    localparam logic [1:0] KIND_LEADING  = 2'd0;
    localparam logic [1:0] KIND_TRAILING = 2'd1;
    localparam logic [1:0] KIND_SUMMARY  = 2'd2;

    // Highest valid module number
    localparam logic [6:0] MODULE_MAX = 7'd124;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [6:0]  module_number;
        logic [7:0]  global_channel;
        logic [20:0] hit_time;
        logic [31:0] raw_word;
        logic        trigger_seen_flag;
        logic        last_result;
    } result_t;

    // Results produced by one decoded word
    typedef struct packed {
        logic    hit_valid;
        result_t hit;
        logic    sum_valid;
        result_t summary;
    } decode_t;

endpackage

// ===== hdl/tdu_decode.sv =====
// Word decoder and per-event state for the TDC data word unpacker.
// Decodes one registered word into up to two results and updates the event state.
// Depends on tdu_pkg.
module tdu_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [31:0]     data_word,
    input  logic            first_word,
    input  logic            last_word,
    output tdu_pkg::decode_t dec
);
    import tdu_pkg::*;

    logic        geo_valid_reg,    geo_valid_next;
    logic        half_module_reg,  half_module_next;
    logic [6:0]  module_id_reg,    module_id_next;
    logic [31:0] trigger_word_reg, trigger_word_next;
    logic        trigger_seen_reg, trigger_seen_next;

    logic        geo_cur;
    logic        half_cur;
    logic [6:0]  mod_cur;
    logic [31:0] trig_cur;
    logic        seen_cur;
    logic [3:0]  tag;
    logic [3:0]  tdc;
    logic [2:0]  chan;
    logic        is_hit;

    assign tag  = data_word[31:28];
    assign tdc  = data_word[27:24];
    assign chan = data_word[23:21];

    // First word starts from a cleared event
    assign geo_cur  = first_word ? 1'b0  : geo_valid_reg;
    assign half_cur = first_word ? 1'b0  : half_module_reg;
    assign mod_cur  = first_word ? 7'd0  : module_id_reg;
    assign trig_cur = first_word ? 32'd0 : trigger_word_reg;
    assign seen_cur = first_word ? 1'b0  : trigger_seen_reg;

    // State update by tag
    always_comb
    begin
        geo_valid_next    = geo_cur;
        half_module_next  = half_cur;
        module_id_next    = mod_cur;
        trigger_word_next = trig_cur;
        trigger_seen_next = seen_cur;
        is_hit            = 1'b0;
        unique case (tag)
            TAG_TRIGGER:
            begin
                if (!seen_cur)
                begin
                    trigger_word_next = data_word;
                    trigger_seen_next = 1'b1;
                end
            end
            TAG_GEO:
            begin
                half_module_next = data_word[0];
                module_id_next   = data_word[7:1];
                geo_valid_next   = 1'b1;
            end
            TAG_LEADING, TAG_TRAILING:
            begin
                is_hit = geo_cur && (mod_cur != 7'd0) && (mod_cur <= MODULE_MAX);
            end
            default:
            begin
                is_hit = 1'b0;
            end
        endcase
    end

    // Hit and summary results
    always_comb
    begin
        dec.hit_valid                = is_hit;
        dec.hit.result_kind          = (tag == TAG_LEADING) ? KIND_LEADING : KIND_TRAILING;
        dec.hit.module_number        = mod_cur;
        dec.hit.global_channel       = 8'(chan) + {3'd0, tdc[1:0], 3'd0}
                                       + {2'd0, tdc[3:2], 4'd0} + {3'd0, tdc[3:2], 3'd0}
                                       + (half_cur ? 8'd96 : 8'd0);
        dec.hit.hit_time             = {data_word[18:0], data_word[20:19]};
        dec.hit.raw_word             = data_word;
        dec.hit.trigger_seen_flag    = 1'b0;
        dec.hit.last_result          = !last_word;

        dec.sum_valid                = last_word;
        dec.summary.result_kind      = KIND_SUMMARY;
        dec.summary.module_number    = 7'd0;
        dec.summary.global_channel   = 8'd0;
        dec.summary.hit_time         = 21'd0;
        dec.summary.raw_word         = trigger_word_next;
        dec.summary.trigger_seen_flag = trigger_seen_next;
        dec.summary.last_result      = 1'b1;
    end

    // Event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_valid_reg    <= 1'b0;
            half_module_reg  <= 1'b0;
            module_id_reg    <= 7'd0;
            trigger_word_reg <= 32'd0;
            trigger_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            geo_valid_reg    <= geo_valid_next;
            half_module_reg  <= half_module_next;
            module_id_reg    <= module_id_next;
            trigger_word_reg <= trigger_word_next;
            trigger_seen_reg <= trigger_seen_next;
        end
    end

endmodule

// ===== hdl/tdu_result_fifo.sv =====
// Result queue for the TDC data word unpacker: takes up to two results
// per cycle, gives one per cycle while pop is high. Depends on tdu_pkg.
module tdu_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push0,
    input  tdu_pkg::result_t data0,
    input  logic             push1,
    input  tdu_pkg::result_t data1,
    output logic             room2,
    output logic             head_valid,
    output tdu_pkg::result_t head,
    input  logic             pop
);
    import tdu_pkg::*;

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [PTR_W-1:0]   wr_addr1;
    logic [1:0]         n_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign room2      = (count_reg <= CNT_W'(DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    assign wr_addr1   = ptr_inc(wr_ptr_reg);

    // Pointer and count update; push1 alone is packed into the first slot
    always_comb
    begin
        n_push      = {1'b0, push0} + {1'b0, push1};
        wr_ptr_next = wr_ptr_reg;
        if (n_push == 2'd1)
            wr_ptr_next = wr_addr1;
        else if (n_push == 2'd2)
            wr_ptr_next = ptr_inc(wr_addr1);
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[wr_ptr_reg] <= data0;
            if (push1)
                entry_reg[wr_addr1] <= data1;
        end
        else if (push1)
        begin
            entry_reg[wr_ptr_reg] <= data1;
        end
    end

endmodule

// ===== hdl/tdc_data_word_unpacker.sv =====
// Top level of the TDC data word unpacker: input register, decoder, result queue.
// Depends on tdu_pkg, tdu_decode and tdu_result_fifo.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | data_word, first_word, last_word
//   out     | out_valid / out_ready| result_kind, module_number, global_channel,
//           |                      | hit_time, raw_word, trigger_seen_flag,
//           |                      | last_result
//
// One item per cycle is accepted while two queue entries are free; its results pass
// from the input register into the result queue and are on the outputs from there.
// The held item waits in the input register while fewer than two queue entries
// are free, whether it gives one result or two.
// Reset clears the event state, the input register and the queue.
// out_ready low fills the RESULT_DEPTH-entry queue; in_ready drops once fewer
// than two entries are free.
module tdc_data_word_unpacker #(
    parameter int RESULT_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic        first_word,
    input  logic        last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [6:0]  module_number,
    output logic [7:0]  global_channel,
    output logic [20:0] hit_time,
    output logic [31:0] raw_word,
    output logic        trigger_seen_flag,
    output logic        last_result
);
    import tdu_pkg::*;

    logic        ivalid_reg;
    logic [31:0] iword_reg;
    logic        ifirst_reg;
    logic        ilast_reg;
    logic        step;
    logic        room2;
    decode_t     dec;
    result_t     head;

    // Decode the held item when the queue can take both possible results
    assign step     = ivalid_reg && room2;
    assign in_ready = !ivalid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ivalid_reg <= 1'b0;
        else if (in_ready)
            ivalid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            iword_reg  <= data_word;
            ifirst_reg <= first_word;
            ilast_reg  <= last_word;
        end
    end

    tdu_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_word  (iword_reg),
        .first_word (ifirst_reg),
        .last_word  (ilast_reg),
        .dec        (dec)
    );

    tdu_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (step && dec.hit_valid),
        .data0      (dec.hit),
        .push1      (step && dec.sum_valid),
        .data1      (dec.summary),
        .room2      (room2),
        .head_valid (out_valid),
        .head       (head),
        .pop        (out_ready)
    );

    // Result fields
    assign result_kind       = head.result_kind;
    assign module_number     = head.module_number;
    assign global_channel    = head.global_channel;
    assign hit_time          = head.hit_time;
    assign raw_word          = head.raw_word;
    assign trigger_seen_flag = head.trigger_seen_flag;
    assign last_result       = head.last_result;

endmodule

// ===== tb/tdc_data_word_unpacker_tb.sv =====
// Self-checking testbench for tdc_data_word_unpacker: drives readout words of whole
// events, predicts hit and summary results and compares them in order.
// Depends on tdu_pkg and the RTL of the unpacker.
module tdc_data_word_unpacker_tb;

    import tdu_pkg::*;

    localparam int          WORD_TARGET = 1050;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          IDLE_PCT    = 12;
    localparam int          HOLD_AT     = 300;
    localparam int          HOLD_CYCLES = 150;
    localparam int          QUIET_FROM  = 600;
    localparam int          QUIET_TO    = 800;
    localparam int          DRAIN_WAIT  = 16;

    // Tags that the unpacker has no use for
    localparam logic [3:0] TAG_OTHER_LO = 4'h0;
    localparam logic [3:0] TAG_OTHER_HI = 4'hF;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] data_word;
    logic        first_word;
    logic        last_word;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [6:0]  module_number;
    logic [7:0]  global_channel;
    logic [20:0] hit_time;
    logic [31:0] raw_word;
    logic        trigger_seen_flag;
    logic        last_result;

    int          words_in;
    int unsigned cycle_count;

    // Event decoder model and the queue of results it still waits for
    class result_scoreboard;
        result_t     expected_results[$];
        int          errors;
        logic        geo_ok;
        logic        half_bit;
        logic [6:0]  module_id;
        logic [31:0] trig_word;
        logic        trig_seen;

        function new();
            errors = 0;
            clear_event();
        endfunction

        function void clear_event();
            geo_ok    = 1'b0;
            half_bit  = 1'b0;
            module_id = '0;
            trig_word = '0;
            trig_seen = 1'b0;
        endfunction

        // Decode one accepted word and queue what it should produce
        function void decode_word(logic [31:0] w, logic first, logic last);
            result_t     step_q[$];
            result_t     r;
            logic [3:0]  tag;
            int unsigned tdc;
            int unsigned chan;
            int unsigned gch;
            tag = w[31:28];
            if (first)
                clear_event();
            if (tag == TAG_HEADER || tag == TAG_SEPARATE || tag == TAG_TRIG_FLG) begin
                // skipped
            end
            else if (tag == TAG_TRIGGER) begin
                if (!trig_seen) begin
                    trig_word = w;
                    trig_seen = 1'b1;
                end
            end
            else if (tag == TAG_GEO) begin
                half_bit  = w[0];
                module_id = w[7:1];
                geo_ok    = 1'b1;
            end
            else if (geo_ok && module_id >= 7'd1 && module_id <= MODULE_MAX &&
                     (tag == TAG_LEADING || tag == TAG_TRAILING)) begin
                tdc  = w[27:24];
                chan = w[23:21];
                gch  = chan + (tdc % 4) * 8 + (tdc / 4) * 24 + half_bit * 96;
                r.result_kind       = (tag == TAG_LEADING) ? KIND_LEADING : KIND_TRAILING;
                r.module_number     = module_id;
                r.global_channel    = 8'(gch);
                r.hit_time          = {w[18:0], 2'b00} + 21'(w[20:19]);
                r.raw_word          = w;
                r.trigger_seen_flag = 1'b0;
                r.last_result       = 1'b0;
                step_q.insert(step_q.size(), r);
            end
            if (last) begin
                r.result_kind       = KIND_SUMMARY;
                r.module_number     = '0;
                r.global_channel    = '0;
                r.hit_time          = '0;
                r.raw_word          = trig_word;
                r.trigger_seen_flag = trig_seen;
                r.last_result       = 1'b0;
                step_q.insert(step_q.size(), r);
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last_result = 1'b1;
            foreach (step_q[i])
                expected_results.insert(expected_results.size(), step_q[i]);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one result from the block against the oldest expectation
        task check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result (raw_word)", got.raw_word, 32'd0);
                return;
            end
            want = expected_results.pop_front();
            if (got.result_kind != want.result_kind)
                report("result_kind", got.result_kind, want.result_kind);
            if (got.module_number != want.module_number)
                report("module_number", got.module_number, want.module_number);
            if (got.global_channel != want.global_channel)
                report("global_channel", got.global_channel, want.global_channel);
            if (got.hit_time != want.hit_time)
                report("hit_time", got.hit_time, want.hit_time);
            if (got.raw_word != want.raw_word)
                report("raw_word", got.raw_word, want.raw_word);
            if (got.trigger_seen_flag != want.trigger_seen_flag)
                report("trigger_seen_flag", got.trigger_seen_flag, want.trigger_seen_flag);
            if (got.last_result != want.last_result)
                report("last_result", got.last_result, want.last_result);
        endtask
    endclass

    result_scoreboard sb = new();

    tdc_data_word_unpacker u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_word         (data_word),
        .first_word        (first_word),
        .last_word         (last_word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .module_number     (module_number),
        .global_channel    (global_channel),
        .hit_time          (hit_time),
        .raw_word          (raw_word),
        .trigger_seen_flag (trigger_seen_flag),
        .last_result       (last_result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic quiet_window();
        return words_in >= QUIET_FROM && words_in < QUIET_TO;
    endfunction

    // Monitor: note accepted words first, then check results of the same edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.decode_word(data_word, first_word, last_word);
                words_in++;
            end
            if (out_valid && out_ready)
                sb.check_result(result_t'({result_kind, module_number, global_channel,
                                           hit_time, raw_word, trigger_seen_flag,
                                           last_result}));
        end
    end

    // Receiver: random stalls, one long hold-off to back up the input
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && words_in >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (quiet_window())
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one item, with a random gap first, and wait for its acceptance
    task send_word(input logic [31:0] w, input logic first, input logic last);
        while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= w;
        first_word <= first;
        last_word  <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [31:0] tagged_word(logic [3:0] tag);
        return {tag, 28'($urandom)};
    endfunction

    function automatic logic [31:0] geo_word(logic [6:0] module_num, logic half);
        return {TAG_GEO, 20'($urandom), module_num, half};
    endfunction

    // One random event: header, triggers, geographic groups with hits, last word
    task random_event();
        int         n_groups;
        int         n_hits;
        int         pick;
        logic [6:0] module_num;
        logic       first;
        first = ($urandom_range(9) != 0);
        send_word(tagged_word(TAG_HEADER), first, 1'b0);
        if ($urandom_range(3) != 0)
            send_word(tagged_word(TAG_TRIGGER), 1'b0, 1'b0);
        if ($urandom_range(4) == 0)
            send_word(tagged_word(TAG_TRIGGER), 1'b0, 1'b0);
        n_groups = $urandom_range(1, 3);
        for (int g = 0; g < n_groups; g++) begin
            if ($urandom_range(99) < 85)
                module_num = 7'($urandom_range(1, MODULE_MAX));
            else begin
                pick = $urandom_range(3);
                module_num = (pick == 0) ? 7'd0 : 7'(MODULE_MAX + pick);
            end
            send_word(geo_word(module_num, 1'($urandom)), 1'b0, 1'b0);
            n_hits = $urandom_range(0, 5);
            for (int h = 0; h < n_hits; h++) begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_word(tagged_word(TAG_LEADING), 1'b0, 1'b0);
                else if (pick < 90)
                    send_word(tagged_word(TAG_TRAILING), 1'b0, 1'b0);
                else if (pick < 95)
                    send_word($urandom, 1'b0, 1'b0);
                else
                    send_word(tagged_word(TAG_SEPARATE), 1'b0, 1'b0);
            end
        end
        // broken events now and then end without a last word
        pick = $urandom_range(19);
        if (pick < 9)
            send_word(tagged_word($urandom_range(1) ? TAG_LEADING : TAG_TRAILING), 1'b0, 1'b1);
        else if (pick < 19)
            send_word(tagged_word(TAG_SEPARATE), 1'b0, 1'b1);
    endtask

    // Main stimulus
    initial
    begin
        words_in   = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_word  <= '0;
        first_word <= 1'b0;
        last_word  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hit before any geographic word is dropped
        send_word(tagged_word(TAG_LEADING), 1'b1, 1'b0);
        send_word(tagged_word(TAG_HEADER), 1'b0, 1'b0);
        // only the first trigger word is kept
        send_word({TAG_TRIGGER, 28'h0000000}, 1'b0, 1'b0);
        send_word({TAG_TRIGGER, 28'hFFFFFFF}, 1'b0, 1'b0);
        // lowest and highest module, field extremes
        send_word(geo_word(7'd1, 1'b0), 1'b0, 1'b0);
        send_word({TAG_LEADING, 28'hFFFFFFF}, 1'b0, 1'b0);
        send_word({TAG_TRAILING, 28'h0000000}, 1'b0, 1'b0);
        send_word(geo_word(MODULE_MAX, 1'b1), 1'b0, 1'b0);
        send_word({TAG_LEADING, 28'hFFFFFFF}, 1'b0, 1'b0);
        send_word(tagged_word(TAG_TRIG_FLG), 1'b0, 1'b0);
        send_word(tagged_word(TAG_SEPARATE), 1'b0, 1'b0);
        // out-of-range modules drop the hits after them
        send_word(geo_word(7'd0, 1'b1), 1'b0, 1'b0);
        send_word(tagged_word(TAG_TRAILING), 1'b0, 1'b0);
        send_word(geo_word(7'd125, 1'b0), 1'b0, 1'b0);
        send_word(tagged_word(TAG_LEADING), 1'b0, 1'b0);
        send_word(geo_word(7'd127, 1'b1), 1'b0, 1'b0);
        send_word(tagged_word(TAG_TRAILING), 1'b0, 1'b0);
        // unknown tags
        send_word({TAG_OTHER_LO, 28'($urandom)}, 1'b0, 1'b0);
        send_word({TAG_OTHER_HI, 28'($urandom)}, 1'b0, 1'b0);
        // last word that is also a hit: hit then summary
        send_word(geo_word(7'd64, 1'b1), 1'b0, 1'b0);
        send_word(tagged_word(TAG_TRAILING), 1'b0, 1'b1);
        // first and last on one word
        send_word(tagged_word(TAG_LEADING), 1'b1, 1'b1);
        send_word(tagged_word(TAG_TRIGGER), 1'b1, 1'b1);
        // event that opens with a geographic word on its first word keeps the hit after it
        send_word(geo_word(7'd10, 1'b0), 1'b1, 1'b0);
        send_word(tagged_word(TAG_LEADING), 1'b0, 1'b1);

        while (words_in < WORD_TARGET)
            random_event();

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
